>>> rtl/core/htfd_pkg.sv
// ----------------------------------------------------------------------------
// Humidity/temperature frame decoder package
// Shared constants, status codes and the byte-wide CRC-8 update function.
// ----------------------------------------------------------------------------
`default_nettype none

package htfd_pkg;

    localparam logic [7:0]  CRC_POLY   = 8'h31;
    localparam logic [7:0]  CRC_INIT   = 8'hFF;
    localparam int unsigned BUSY_BIT   = 7;
    localparam logic [2:0]  LAST_INDEX = 3'd6;
    localparam logic [9:0]  RH_SCALE   = 10'd625;
    localparam logic [10:0] T_SCALE    = 11'd1250;
    localparam logic [14:0] T_OFFSET   = 15'd5000;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BUSY = 2'd1,
        ST_CRC  = 2'd2
    } status_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/humidity_temp_frame_decoder.sv
// ----------------------------------------------------------------------------
// Humidity/temperature frame decoder
// One byte is accepted per cycle unless the output holds an unread result; a
// frame's result is registered in the cycle after its seventh byte.
// Synchronous active-low reset closes any open frame and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_temp_frame_decoder (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_data_byte,
    input  wire logic               s_frame_start,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_result_status,
    output logic signed [14:0]      m_temperature_c100,
    output logic [13:0]             m_humidity_c100
);

    logic [2:0]  byte_index_reg, byte_index_next;
    logic        in_frame_reg, in_frame_next;
    logic [7:0]  crc_reg, crc_next;
    logic        busy_seen_reg, busy_seen_next;
    logic [19:0] humidity_raw_reg, humidity_raw_next;
    logic [19:0] temperature_raw_reg, temperature_raw_next;

    logic                 m_valid_reg, m_valid_next;
    htfd_pkg::status_t    status_reg, status_next;
    logic [14:0]          temp_reg, temp_next;
    logic [13:0]          hum_reg, hum_next;

    logic        accept;
    logic        active;
    logic        produce;
    logic [2:0]  idx;
    logic [7:0]  crc_base;
    logic [29:0] h_prod;
    logic [30:0] t_prod;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign active  = s_frame_start || in_frame_reg;
    assign idx      = s_frame_start ? 3'd0 : byte_index_reg;
    assign crc_base = s_frame_start ? htfd_pkg::CRC_INIT : crc_reg;
    assign produce  = accept && active && (idx >= htfd_pkg::LAST_INDEX);

    assign h_prod = 30'(humidity_raw_reg) * 30'(htfd_pkg::RH_SCALE);
    assign t_prod = 31'(temperature_raw_reg) * 31'(htfd_pkg::T_SCALE);

    always_comb begin
        byte_index_next      = byte_index_reg;
        in_frame_next        = in_frame_reg;
        crc_next             = crc_reg;
        busy_seen_next       = busy_seen_reg;
        humidity_raw_next    = humidity_raw_reg;
        temperature_raw_next = temperature_raw_reg;
        if (accept && active) begin
            case (idx)
                3'd0: busy_seen_next = s_data_byte[htfd_pkg::BUSY_BIT];
                3'd1: humidity_raw_next[19:12] = s_data_byte;
                3'd2: humidity_raw_next[11:4] = s_data_byte;
                3'd3: begin
                    humidity_raw_next[3:0]     = s_data_byte[7:4];
                    temperature_raw_next[19:16] = s_data_byte[3:0];
                end
                3'd4: temperature_raw_next[15:8] = s_data_byte;
                3'd5: temperature_raw_next[7:0] = s_data_byte;
                default: ;
            endcase
            if (idx < htfd_pkg::LAST_INDEX) begin
                crc_next        = htfd_pkg::crc8_update(crc_base, s_data_byte);
                byte_index_next = idx + 3'd1;
                in_frame_next   = 1'b1;
            end else begin
                crc_next        = htfd_pkg::CRC_INIT;
                byte_index_next = 3'd0;
                in_frame_next   = 1'b0;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        temp_next    = temp_reg;
        hum_next     = hum_reg;
        if (produce) begin
            m_valid_next = 1'b1;
            temp_next    = 15'd0;
            hum_next     = 14'd0;
            if (busy_seen_reg) begin
                status_next = htfd_pkg::ST_BUSY;
            end else if (crc_reg != s_data_byte) begin
                status_next = htfd_pkg::ST_CRC;
            end else begin
                status_next = htfd_pkg::ST_OK;
                hum_next    = h_prod[29:16];
                temp_next   = t_prod[30:16] - htfd_pkg::T_OFFSET;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg <= 3'd0;
            in_frame_reg   <= 1'b0;
            crc_reg        <= htfd_pkg::CRC_INIT;
            busy_seen_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            byte_index_reg <= byte_index_next;
            in_frame_reg   <= in_frame_next;
            crc_reg        <= crc_next;
            busy_seen_reg  <= busy_seen_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        humidity_raw_reg    <= humidity_raw_next;
        temperature_raw_reg <= temperature_raw_next;
        status_reg          <= status_next;
        temp_reg            <= temp_next;
        hum_reg             <= hum_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_result_status    = status_reg;
    assign m_temperature_c100 = temp_reg;
    assign m_humidity_c100    = hum_reg;

    a_idle_index : assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> byte_index_reg == 3'd0)
        else $error("byte index nonzero outside a frame");

    a_fail_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (status_reg != htfd_pkg::ST_OK) |-> temp_reg == 15'd0 && hum_reg == 14'd0)
        else $error("nonzero values on a failed result");

    a_hum_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (status_reg == htfd_pkg::ST_OK) |-> hum_reg <= 14'd9999)
        else $error("humidity out of range");

endmodule

`default_nettype wire
